@@ rtl/dual_led_string_frame_serializer_macros.svh @@
// Assertion macros for the dual LED string frame serializer checker.
// No dependencies; included by the checker file.
`ifndef DUAL_LED_STRING_FRAME_SERIALIZER_MACROS_SVH
`define DUAL_LED_STRING_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define DLSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dlss assertion failed");

// Next-cycle implication, gated off during reset.
`define DLSS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dlss assertion failed");

`endif

@@ rtl/dlss_pkg.sv @@
// Shared types and constants for the dual LED string frame serializer.
// No dependencies.
package dlss_pkg;

    localparam int FRAME_BITS = 26;
    localparam int ADDR_BITS  = 6;
    localparam int NUM_BITS   = 7;
    localparam int COUNT_BITS = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [1:0] symbol_t;
    localparam symbol_t SYM_HOLD = 2'd0;
    localparam symbol_t SYM_ZERO = 2'd1;
    localparam symbol_t SYM_ONE  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic   load;
        logic   tick;
        frame_t frame;
    } line_ctrl_t;

    typedef struct packed {
        symbol_t symbol;
        logic    idle;
        logic    busy_next;
    } line_stat_t;

endpackage

@@ rtl/dlss_line.sv @@
// One LED line: frame shifter, bit counter and phase sequencer.
// Depends on dlss_pkg.
module dlss_line (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dlss_pkg::line_ctrl_t ctrl,
    output dlss_pkg::line_stat_t stat
);

    dlss_pkg::phase_t                      phase_reg, phase_next;
    logic [dlss_pkg::COUNT_BITS-1:0]       count_reg, count_next;
    dlss_pkg::frame_t                      frame_reg, frame_next;
    dlss_pkg::symbol_t                     pending_reg, pending_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= dlss_pkg::PH_IDLE;
            count_reg   <= '0;
            pending_reg <= dlss_pkg::SYM_HOLD;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        frame_next   = frame_reg;
        pending_next = pending_reg;
        if (ctrl.load) begin
            phase_next   = dlss_pkg::PH_START;
            count_next   = '0;
            frame_next   = ctrl.frame;
            pending_next = dlss_pkg::SYM_ONE;
        end else if (ctrl.tick) begin
            unique case (phase_reg)
                dlss_pkg::PH_START, dlss_pkg::PH_DATA: begin
                    if (count_reg < dlss_pkg::COUNT_BITS'(dlss_pkg::FRAME_BITS)) begin
                        phase_next   = dlss_pkg::PH_DATA;
                        pending_next = frame_reg[dlss_pkg::FRAME_BITS-1] ?
                                       dlss_pkg::SYM_ONE : dlss_pkg::SYM_ZERO;
                        frame_next   = {frame_reg[dlss_pkg::FRAME_BITS-2:0], 1'b0};
                        count_next   = count_reg + 1'b1;
                    end else begin
                        phase_next   = dlss_pkg::PH_STOP;
                        pending_next = dlss_pkg::SYM_HOLD;
                    end
                end
                dlss_pkg::PH_STOP: begin
                    phase_next   = dlss_pkg::PH_IDLE;
                    pending_next = dlss_pkg::SYM_HOLD;
                    count_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.symbol    = pending_reg;
    assign stat.idle      = (phase_reg == dlss_pkg::PH_IDLE);
    assign stat.busy_next = (phase_next != dlss_pkg::PH_IDLE);

endmodule

@@ rtl/dual_led_string_frame_serializer.sv @@
// Top level of the dual LED string frame serializer.
// Depends on dlss_pkg and dlss_line.
//
// Usage:
//   s_* channel (valid/ready) carries requests: cmd 0 loads a colour message
//   for the LED named by s_led_number, cmd 1 is one bit-time tick.
//   m_* channel (valid/ready) returns one result per request: the symbol
//   shown on each line this tick, whether a load was taken, and the busy
//   flag of each line after the request.
//   cfg_* channel writes the line-one LED count (numbers at or above it go to
//   line two). Write it only while no request is in flight; cfg_ready is high.
// Timing:
//   One request per cycle sustained while m_ready is high. A request is held
//   in the input register; its result then moves into the output register,
//   which raises m_valid. Both lines update as that register is loaded.
// Reset:
//   Both lines idle, holding low; the line-one LED count returns to 35.
// Stall:
//   While m_ready is low a held result blocks the input register; s_ready
//   drops once that register is full, so no request is lost.
module dual_led_string_frame_serializer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [6:0] s_led_number,
    input  logic [7:0] s_brightness,
    input  logic [7:0] s_green_red,
    input  logic [3:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_line_one_symbol,
    output logic [1:0] m_line_two_symbol,
    output logic       m_accepted,
    output logic       m_line_one_busy,
    output logic       m_line_two_busy,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    logic       in_valid_reg;
    logic       cmd_reg;
    logic [6:0] num_reg;
    logic [7:0] bright_reg;
    logic [7:0] gr_reg;
    logic [3:0] blue_reg;
    logic [5:0] lps_reg;

    logic       out_valid_reg;
    logic [1:0] sym_one_reg, sym_one_next;
    logic [1:0] sym_two_reg, sym_two_next;
    logic       acc_reg, acc_next;
    logic       busy_one_reg, busy_two_reg;

    logic       advance;
    logic       to_line_one;
    logic [5:0] addr_two;

    dlss_pkg::line_ctrl_t ctrl_one, ctrl_two;
    dlss_pkg::line_stat_t stat_one, stat_two;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lps_reg       <= 6'd35;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                lps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg    <= s_cmd;
            num_reg    <= s_led_number;
            bright_reg <= s_brightness;
            gr_reg     <= s_green_red;
            blue_reg   <= s_blue;
        end
        if (advance) begin
            sym_one_reg  <= sym_one_next;
            sym_two_reg  <= sym_two_next;
            acc_reg      <= acc_next;
            busy_one_reg <= stat_one.busy_next;
            busy_two_reg <= stat_two.busy_next;
        end
    end

    assign to_line_one = (num_reg < {1'b0, lps_reg});
    assign addr_two    = dlss_pkg::ADDR_BITS'(num_reg - {1'b0, lps_reg});

    always_comb begin
        ctrl_one.load  = advance && (cmd_reg == dlss_pkg::CMD_LOAD) && to_line_one
                         && stat_one.idle;
        ctrl_two.load  = advance && (cmd_reg == dlss_pkg::CMD_LOAD) && !to_line_one
                         && stat_two.idle;
        ctrl_one.tick  = advance && (cmd_reg == dlss_pkg::CMD_TICK);
        ctrl_two.tick  = ctrl_one.tick;
        ctrl_one.frame = {num_reg[dlss_pkg::ADDR_BITS-1:0], bright_reg, blue_reg, gr_reg};
        ctrl_two.frame = {addr_two, bright_reg, blue_reg, gr_reg};
        acc_next       = ctrl_one.load || ctrl_two.load;
        sym_one_next   = (cmd_reg == dlss_pkg::CMD_TICK) ? stat_one.symbol
                                                         : dlss_pkg::SYM_HOLD;
        sym_two_next   = (cmd_reg == dlss_pkg::CMD_TICK) ? stat_two.symbol
                                                         : dlss_pkg::SYM_HOLD;
    end

    dlss_line u_line_one (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_one),
        .stat    (stat_one)
    );

    dlss_line u_line_two (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_two),
        .stat    (stat_two)
    );

    assign m_valid           = out_valid_reg;
    assign m_line_one_symbol = sym_one_reg;
    assign m_line_two_symbol = sym_two_reg;
    assign m_accepted        = acc_reg;
    assign m_line_one_busy   = busy_one_reg;
    assign m_line_two_busy   = busy_two_reg;

endmodule

@@ rtl/dlss_checker.sv @@
// Port-level checker for the dual LED string frame serializer, with its bind.
// Depends on dlss_pkg and dual_led_string_frame_serializer_macros.svh.
`include "dual_led_string_frame_serializer_macros.svh"

module dlss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_line_one_symbol,
    input logic [1:0] m_line_two_symbol,
    input logic       m_accepted,
    input logic       m_line_one_busy,
    input logic       m_line_two_busy
);

    logic [7:0] result_bits;
    logic       out_waiting;
    logic       load_quiet;
    logic       one_pulse;
    logic       two_pulse;
    logic       one_pulse_ok;
    logic       two_pulse_ok;

    assign result_bits  = {m_line_one_symbol, m_line_two_symbol, m_accepted,
                           m_line_one_busy, m_line_two_busy};
    assign out_waiting  = m_valid && !m_ready;
    assign load_quiet   = (m_line_one_busy || m_line_two_busy)
                          && m_line_one_symbol == dlss_pkg::SYM_HOLD
                          && m_line_two_symbol == dlss_pkg::SYM_HOLD;
    assign one_pulse    = m_valid && m_line_one_symbol != dlss_pkg::SYM_HOLD;
    assign two_pulse    = m_valid && m_line_two_symbol != dlss_pkg::SYM_HOLD;
    assign one_pulse_ok = m_line_one_busy && (m_line_one_symbol == dlss_pkg::SYM_ZERO
                                              || m_line_one_symbol == dlss_pkg::SYM_ONE);
    assign two_pulse_ok = m_line_two_busy && (m_line_two_symbol == dlss_pkg::SYM_ZERO
                                              || m_line_two_symbol == dlss_pkg::SYM_ONE);

    // held result must not change
    `DLSS_ASSERT_NXT(a_out_hold, aclk, aresetn, out_waiting, m_valid && $stable(result_bits))

    // a taken load leaves some line busy and shows no pulse
    `DLSS_ASSERT_IMP(a_acc_busy, aclk, aresetn, m_valid && m_accepted, load_quiet)

    // a pulse on a line means the frame is still running
    `DLSS_ASSERT_IMP(a_one_pulse, aclk, aresetn, one_pulse, one_pulse_ok)

    `DLSS_ASSERT_IMP(a_two_pulse, aclk, aresetn, two_pulse, two_pulse_ok)

endmodule

bind dual_led_string_frame_serializer dlss_checker u_dlss_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_line_one_symbol (m_line_one_symbol),
    .m_line_two_symbol (m_line_two_symbol),
    .m_accepted        (m_accepted),
    .m_line_one_busy   (m_line_one_busy),
    .m_line_two_busy   (m_line_two_busy)
);
